// ===== rtl/psat_pkg.sv =====
// psat_pkg: shared widths, result kinds, command codes and small types
// for the packet sequence ack tracker. Depends on nothing.

package psat_pkg;

    localparam int ACK_WINDOW_DEF = 32;
    localparam int SEQ_W          = 16;
    localparam int CNT_W          = 32;
    localparam int GAP_W          = 15;
    localparam int KIND_W         = 3;
    localparam int VIEW_W         = 32;

    // half of the sequence space: largest forward distance that counts as newer
    localparam logic [SEQ_W-1:0] SEQ_HALF = 16'h8000;

    // command codes on the request channel
    localparam logic CMD_RX = 1'b0;
    localparam logic CMD_TX = 1'b1;

    typedef enum logic [KIND_W-1:0] {
        KIND_SENT        = 3'd0,
        KIND_FIRST       = 3'd1,
        KIND_DUPLICATE   = 3'd2,
        KIND_IN_ORDER    = 3'd3,
        KIND_GAP         = 3'd4,
        KIND_LATE_FILLED = 3'd5,
        KIND_LATE_SEEN   = 3'd6,
        KIND_TOO_OLD     = 3'd7
    } kind_t;

    // receive-side tracking state apart from the ack bits
    typedef struct packed {
        logic             seen_first;
        logic [SEQ_W-1:0] latest;
        logic [CNT_W-1:0] lost;
    } track_t;

    // outcome of one received packet
    typedef struct packed {
        kind_t            kind;
        logic [GAP_W-1:0] gap;
    } rx_res_t;

    // saturating 32-bit add
    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                 input logic [CNT_W-1:0] b);
        logic [CNT_W:0] s;
        begin
            s = {1'b0, a} + {1'b0, b};
            return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
        end
    endfunction

endpackage

// ===== rtl/psat_if.sv =====
// psat_if: valid/ready channel interfaces for the request and report beats
// of the packet sequence ack tracker. Depends on nothing.

interface psat_req_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [15:0] rx_sequence;

    modport source (output valid, output cmd, output rx_sequence, input ready);
    modport sink   (input valid, input cmd, input rx_sequence, output ready);
endinterface

interface psat_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  result_kind;
    logic [15:0] tx_sequence;
    logic [15:0] ack_latest;
    logic [31:0] ack_window;
    logic [14:0] gap_count;
    logic [31:0] lost_total;
    logic [31:0] sent_total;
    logic [31:0] received_total;

    modport source (output valid, output result_kind, output tx_sequence,
                    output ack_latest, output ack_window, output gap_count,
                    output lost_total, output sent_total, output received_total,
                    input ready);
    modport sink   (input valid, input result_kind, input tx_sequence,
                    input ack_latest, input ack_window, input gap_count,
                    input lost_total, input sent_total, input received_total,
                    output ready);
endinterface

// ===== rtl/psat_rx_update.sv =====
// psat_rx_update: next receive state for one incoming packet sequence:
// wrapped distance, window shift or late-bit fill, lost estimate. Uses psat_pkg.

module psat_rx_update #(
    parameter int ACK_WINDOW = psat_pkg::ACK_WINDOW_DEF
) (
    input  psat_pkg::track_t                 state,
    input  logic [ACK_WINDOW-1:0]            ack,
    input  logic [psat_pkg::SEQ_W-1:0]       seq,
    output psat_pkg::track_t                 state_next,
    output logic [ACK_WINDOW-1:0]            ack_next,
    output psat_pkg::rx_res_t                res
);
    import psat_pkg::*;

    localparam int SHW = (ACK_WINDOW > 1) ? $clog2(ACK_WINDOW) : 1;
    localparam logic [SEQ_W-1:0] WIN_SEQ = SEQ_W'(ACK_WINDOW);

    logic [SEQ_W-1:0]      delta;
    logic [SEQ_W-1:0]      gap16;
    logic [SEQ_W-1:0]      behind;
    logic [SEQ_W-1:0]      behind_m1;
    logic                  is_newer;
    logic [ACK_WINDOW-1:0] shifted;
    logic [ACK_WINDOW-1:0] gap_bit;
    logic [ACK_WINDOW-1:0] late_bit;

    // wrapped distances from the latest received sequence
    assign delta     = seq - state.latest;
    assign gap16     = delta - SEQ_W'(1);
    assign behind    = SEQ_W'(0) - delta;
    assign behind_m1 = behind - SEQ_W'(1);
    assign is_newer  = (delta != '0) && (delta <= SEQ_HALF);

    // window shift, new bit for the previous latest, bit for a late packet
    assign shifted  = (delta >= WIN_SEQ) ? '0 : (ack << delta[SHW-1:0]);
    assign gap_bit  = (gap16 < WIN_SEQ) ? (ACK_WINDOW'(1) << gap16[SHW-1:0]) : '0;
    assign late_bit = ACK_WINDOW'(1) << behind_m1[SHW-1:0];

    // classify the packet and update the tracking state
    always_comb
    begin
        state_next = state;
        ack_next   = ack;
        res.kind   = KIND_DUPLICATE;
        res.gap    = '0;
        priority if (!state.seen_first)
        begin
            state_next.seen_first = 1'b1;
            state_next.latest     = seq;
            ack_next              = '0;
            res.kind              = KIND_FIRST;
        end
        else if (delta == '0)
        begin
            res.kind = KIND_DUPLICATE;
        end
        else if (is_newer)
        begin
            state_next.lost   = sat_add(state.lost, CNT_W'(gap16[GAP_W-1:0]));
            state_next.latest = seq;
            ack_next          = shifted | gap_bit;
            res.gap           = gap16[GAP_W-1:0];
            res.kind          = (gap16 == '0) ? KIND_IN_ORDER : KIND_GAP;
        end
        else if (behind > WIN_SEQ)
        begin
            res.kind = KIND_TOO_OLD;
        end
        else if ((ack & late_bit) != '0)
        begin
            res.kind = KIND_LATE_SEEN;
        end
        else
        begin
            ack_next        = ack | late_bit;
            state_next.lost = (state.lost != '0) ? (state.lost - CNT_W'(1)) : state.lost;
            res.kind        = KIND_LATE_FILLED;
        end
    end

endmodule

// ===== rtl/packet_sequence_ack_tracker.sv =====
// packet_sequence_ack_tracker: top level; sequence allocation, ack window and
// saturating counters. Uses psat_pkg, psat_req_if, psat_rsp_if, psat_rx_update.
//
//   channel   role   beat contents
//   request   sink   cmd, rx_sequence
//   report    source result_kind, tx_sequence, ack_latest, ack_window,
//                    gap_count, lost_total, sent_total, received_total
//
// one beat per cycle sustained while report.ready holds; a taken beat waits
// in the input register, then passes through the update into the report
// register. rst_n clears all tracking state and both valid flags.
// a stalled report holds its register; the input register still takes a beat
// when it is empty, and request.ready drops only once both stages are full.

module packet_sequence_ack_tracker #(
    parameter int ACK_WINDOW = psat_pkg::ACK_WINDOW_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    psat_req_if.sink   request,
    psat_rsp_if.source report
);
    import psat_pkg::*;

    // input register
    logic             s1_valid_reg;
    logic             s1_cmd_reg;
    logic [SEQ_W-1:0] s1_seq_reg;

    // tracking state
    logic [SEQ_W-1:0]      next_tx_reg;
    logic [ACK_WINDOW-1:0] ack_reg;
    track_t                track_reg;
    logic [CNT_W-1:0]      sent_reg;
    logic [CNT_W-1:0]      recv_reg;

    // report register
    logic              out_valid_reg;
    kind_t             kind_reg;
    logic [SEQ_W-1:0]  tx_seq_reg;
    logic [SEQ_W-1:0]  latest_reg;
    logic [VIEW_W-1:0] window_reg;
    logic [GAP_W-1:0]  gap_reg;
    logic [CNT_W-1:0]  lost_reg;
    logic [CNT_W-1:0]  sent_out_reg;
    logic [CNT_W-1:0]  recv_out_reg;

    // next values
    logic [SEQ_W-1:0]      next_tx_next;
    logic [ACK_WINDOW-1:0] ack_next;
    track_t                track_next;
    logic [CNT_W-1:0]      sent_next;
    logic [CNT_W-1:0]      recv_next;
    kind_t                 kind_next;
    logic [SEQ_W-1:0]      tx_seq_next;
    logic [GAP_W-1:0]      gap_next;
    logic [VIEW_W-1:0]     window_next;

    logic                  advance;
    logic                  accept;
    logic                  fire;
    track_t                rx_track;
    logic [ACK_WINDOW-1:0] rx_ack;
    rx_res_t               rx_res;

    // handshake
    assign advance       = !out_valid_reg || report.ready;
    assign request.ready = !s1_valid_reg || advance;
    assign accept        = request.valid && request.ready;
    assign fire          = s1_valid_reg && advance;

    // receive-side update
    psat_rx_update #(
        .ACK_WINDOW (ACK_WINDOW)
    ) u_rx_update (
        .state      (track_reg),
        .ack        (ack_reg),
        .seq        (s1_seq_reg),
        .state_next (rx_track),
        .ack_next   (rx_ack),
        .res        (rx_res)
    );

    // merge send and receive paths
    always_comb
    begin
        next_tx_next = next_tx_reg;
        ack_next     = ack_reg;
        track_next   = track_reg;
        sent_next    = sent_reg;
        recv_next    = recv_reg;
        kind_next    = KIND_SENT;
        tx_seq_next  = '0;
        gap_next     = '0;
        unique case (s1_cmd_reg)
            CMD_TX:
            begin
                tx_seq_next  = next_tx_reg;
                next_tx_next = next_tx_reg + SEQ_W'(1);
                sent_next    = sat_add(sent_reg, CNT_W'(1));
                kind_next    = KIND_SENT;
            end
            CMD_RX:
            begin
                recv_next  = sat_add(recv_reg, CNT_W'(1));
                track_next = rx_track;
                ack_next   = rx_ack;
                kind_next  = rx_res.kind;
                gap_next   = rx_res.gap;
            end
            default:
            begin
                kind_next = KIND_SENT;
            end
        endcase
    end

    // visible part of the window
    generate
        if (ACK_WINDOW >= VIEW_W)
        begin : g_view_trunc
            assign window_next = ack_next[VIEW_W-1:0];
        end
        else
        begin : g_view_ext
            assign window_next = {{(VIEW_W-ACK_WINDOW){1'b0}}, ack_next};
        end
    endgenerate

    // input register and valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_cmd_reg <= request.cmd;
            s1_seq_reg <= request.rx_sequence;
        end
    end

    // tracking state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_tx_reg <= '0;
            ack_reg     <= '0;
            track_reg   <= '0;
            sent_reg    <= '0;
            recv_reg    <= '0;
        end
        else if (fire)
        begin
            next_tx_reg <= next_tx_next;
            ack_reg     <= ack_next;
            track_reg   <= track_next;
            sent_reg    <= sent_next;
            recv_reg    <= recv_next;
        end
    end

    // report register
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            kind_reg     <= kind_next;
            tx_seq_reg   <= tx_seq_next;
            latest_reg   <= track_next.latest;
            window_reg   <= window_next;
            gap_reg      <= gap_next;
            lost_reg     <= track_next.lost;
            sent_out_reg <= sent_next;
            recv_out_reg <= recv_next;
        end
    end

    assign report.valid          = out_valid_reg;
    assign report.result_kind    = kind_reg;
    assign report.tx_sequence    = tx_seq_reg;
    assign report.ack_latest     = latest_reg;
    assign report.ack_window     = window_reg;
    assign report.gap_count      = gap_reg;
    assign report.lost_total     = lost_reg;
    assign report.sent_total     = sent_out_reg;
    assign report.received_total = recv_out_reg;

endmodule
